FILE: hdl/tdcm_pkg.sv
// ----------------------------------------------------------------------------
// Task-to-device coordinate map: shared types and constants
// Saturating arithmetic helpers, register indexes and the record that
// travels along the row of dimension cells.
// ----------------------------------------------------------------------------
package tdcm_pkg;

	localparam int DIM_LIMIT = 4;
	localparam int COORD_W   = 16;
	localparam int FIELD_W   = 16;
	localparam int INDEX_W   = 32;
	// One bit above the index width marks a value of 2^32 or more.
	localparam int SAT_W     = INDEX_W + 1;

	localparam logic [SAT_W-1:0] SAT_CAP = {1'b1, {INDEX_W{1'b0}}};
	localparam logic [SAT_W-1:0] SAT_ONE = {{(SAT_W-1){1'b0}}, 1'b1};

	localparam logic [2:0] REG_ACTIVE_DIMS   = 3'd0;
	localparam logic [2:0] REG_DEGREES       = 3'd1;
	localparam logic [2:0] REG_STRIDES       = 3'd2;
	localparam logic [2:0] REG_PROJECTION    = 3'd3;
	localparam logic [2:0] REG_START_NODE    = 3'd4;
	localparam logic [2:0] REG_START_DEVICE  = 3'd5;
	localparam logic [2:0] REG_NODE_COUNT    = 3'd6;
	localparam logic [2:0] REG_DEVS_PER_NODE = 3'd7;

	typedef logic [SAT_W-1:0] sat_t;

	// Partial result of one item as it moves from cell to cell. The coordinate
	// for the next cell always sits in the lowest slot.
	typedef struct packed {
		sat_t                               node_sum;
		sat_t                               dev_sum;
		sat_t                               node_coeff;
		sat_t                               dev_coeff;
		logic [DIM_LIMIT-1:0][COORD_W-1:0] coord;
	} acc_t;

	function automatic sat_t sat_mul(input sat_t a, input logic [INDEX_W-1:0] b);
		logic [2*INDEX_W-1:0] p;
		sat_t                 r;
		p = (2*INDEX_W)'(a[INDEX_W-1:0]) * (2*INDEX_W)'(b);
		if (a == '0 || b == '0) begin
			r = '0;
		end else if (a[INDEX_W] || (|p[2*INDEX_W-1:INDEX_W])) begin
			r = SAT_CAP;
		end else begin
			r = {1'b0, p[INDEX_W-1:0]};
		end
		return r;
	endfunction

	function automatic sat_t sat_add(input sat_t a, input sat_t b);
		sat_t s;
		sat_t r;
		s = SAT_W'(a[INDEX_W-1:0]) + SAT_W'(b[INDEX_W-1:0]);
		if (a[INDEX_W] || b[INDEX_W] || s[INDEX_W]) begin
			r = SAT_CAP;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

FILE: hdl/tdcm_if.sv
// ----------------------------------------------------------------------------
// Task-to-device coordinate map: channel interfaces
// Valid/ready channels for task coordinates and for mapped device results.
// ----------------------------------------------------------------------------
interface tdcm_coord_if;
	logic        valid;
	logic        ready;
	logic [15:0] coord_zero;
	logic [15:0] coord_one;
	logic [15:0] coord_two;
	logic [15:0] coord_three;

	modport source (output valid, output coord_zero, output coord_one,
		output coord_two, output coord_three, input ready);
	modport sink (input valid, input coord_zero, input coord_one,
		input coord_two, input coord_three, output ready);
endinterface

interface tdcm_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] node_index;
	logic [31:0] device_index;
	logic        coordinate_valid;

	modport source (output valid, output node_index, output device_index,
		output coordinate_valid, input ready);
	modport sink (input valid, input node_index, input device_index,
		input coordinate_valid, output ready);
endinterface

FILE: hdl/task_to_device_coordinate_map.sv
// ----------------------------------------------------------------------------
// Task-to-device coordinate map
// Each cell has two pipeline stages and the result stage is registered.
// Throughput: one coordinate per cycle while the result channel takes results.
// A stall reaches the input only once every stage ahead of it is full, so
// bubbles are squeezed out.
// Reset clears all stage valid bits and returns the registers to defaults.
// ----------------------------------------------------------------------------
module task_to_device_coordinate_map #(
	parameter int MAX_DIMS   = 4,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_enable,
	input  logic [2:0]  write_index,
	input  logic [63:0] write_data,
	tdcm_coord_if.sink    task_coord,
	tdcm_result_if.source device_coord
);

	localparam logic [tdcm_pkg::COORD_W-1:0] COORD_MASK =
		tdcm_pkg::COORD_W'((32'd1 << COORD_BITS) - 32'd1);
	localparam logic [2:0] DIMS_MAX = 3'(MAX_DIMS);

	logic [2:0]                         active_q;
	logic [63:0]                        degrees_q;
	logic [63:0]                        strides_q;
	logic [3:0]                         projection_q;
	logic [tdcm_pkg::FIELD_W-1:0]       start_node_q;
	logic [tdcm_pkg::FIELD_W-1:0]       start_device_q;
	logic [tdcm_pkg::FIELD_W-1:0]       node_count_q;
	logic [tdcm_pkg::FIELD_W-1:0]       devs_per_node_q;
	logic [2:0]                         dims;

	logic                               chain_valid [MAX_DIMS+1];
	logic                               chain_ready [MAX_DIMS+1];
	tdcm_pkg::acc_t                     chain_data  [MAX_DIMS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 3'd1;
			degrees_q       <= 64'd1;
			strides_q       <= 64'd1;
			projection_q    <= 4'd0;
			start_node_q    <= '0;
			start_device_q  <= '0;
			node_count_q    <= 16'd1;
			devs_per_node_q <= 16'd1;
		end else if (write_enable) begin
			case (write_index)
				tdcm_pkg::REG_ACTIVE_DIMS:   active_q        <= write_data[2:0];
				tdcm_pkg::REG_DEGREES:       degrees_q       <= write_data;
				tdcm_pkg::REG_STRIDES:       strides_q       <= write_data;
				tdcm_pkg::REG_PROJECTION:    projection_q    <= write_data[3:0];
				tdcm_pkg::REG_START_NODE:    start_node_q    <= write_data[15:0];
				tdcm_pkg::REG_START_DEVICE:  start_device_q  <= write_data[15:0];
				tdcm_pkg::REG_NODE_COUNT:    node_count_q    <= write_data[15:0];
				tdcm_pkg::REG_DEVS_PER_NODE: devs_per_node_q <= write_data[15:0];
				default: ;
			endcase
		end
	end

	assign dims = (active_q > DIMS_MAX) ? DIMS_MAX : active_q;

	// Both axes start at their offsets with a unit coefficient.
	always_comb begin
		chain_data[0].node_sum   = tdcm_pkg::SAT_W'(start_node_q);
		chain_data[0].dev_sum    = tdcm_pkg::SAT_W'(start_device_q);
		chain_data[0].node_coeff = tdcm_pkg::SAT_ONE;
		chain_data[0].dev_coeff  = tdcm_pkg::SAT_ONE;
		chain_data[0].coord[0]   = task_coord.coord_zero & COORD_MASK;
		chain_data[0].coord[1]   = task_coord.coord_one & COORD_MASK;
		chain_data[0].coord[2]   = task_coord.coord_two & COORD_MASK;
		chain_data[0].coord[3]   = task_coord.coord_three & COORD_MASK;
	end

	assign chain_valid[0]   = task_coord.valid;
	assign task_coord.ready = chain_ready[0];

	for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cell
		tdcm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.active   (3'(j) < dims),
			.on_node  (projection_q[j]),
			.degree   (degrees_q[j*tdcm_pkg::FIELD_W +: tdcm_pkg::FIELD_W]),
			.stride   (strides_q[j*tdcm_pkg::FIELD_W +: tdcm_pkg::FIELD_W]),
			.up_valid (chain_valid[j]),
			.up_ready (chain_ready[j]),
			.up_data  (chain_data[j]),
			.dn_valid (chain_valid[j+1]),
			.dn_ready (chain_ready[j+1]),
			.dn_data  (chain_data[j+1])
		);
	end

	tdcm_out u_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.node_count       (node_count_q),
		.devices_per_node (devs_per_node_q),
		.up_valid         (chain_valid[MAX_DIMS]),
		.up_ready         (chain_ready[MAX_DIMS]),
		.up_data          (chain_data[MAX_DIMS]),
		.result           (device_coord)
	);

endmodule

FILE: hdl/tdcm_cell.sv
// ----------------------------------------------------------------------------
// Task-to-device coordinate map: dimension cell
// Folds one task dimension, if active, into the node or device index over two stages.
// ----------------------------------------------------------------------------
module tdcm_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                active,
	input  logic                                on_node,
	input  logic [tdcm_pkg::FIELD_W-1:0]        degree,
	input  logic [tdcm_pkg::FIELD_W-1:0]        stride,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  tdcm_pkg::acc_t                      up_data,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output tdcm_pkg::acc_t                      dn_data
);

	logic                                 v_s1;
	logic                                 v_s2;
	logic                                 ready_s1;
	logic                                 ready_s2;
	tdcm_pkg::acc_t                       acc_s1;
	tdcm_pkg::acc_t                       acc_s2;
	tdcm_pkg::sat_t                       part_s1;
	logic [tdcm_pkg::INDEX_W-1:0]         scale_s1;
	tdcm_pkg::sat_t                       sel_coeff;
	tdcm_pkg::sat_t                       coeff_s1;
	tdcm_pkg::sat_t                       idx_s1;
	tdcm_pkg::sat_t                       term;
	tdcm_pkg::sat_t                       new_idx;
	tdcm_pkg::sat_t                       new_coeff;
	tdcm_pkg::acc_t                       next_acc;

	assign ready_s2 = !v_s2 || dn_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign up_ready = ready_s1;
	assign dn_valid = v_s2;
	assign dn_data  = acc_s2;

	assign sel_coeff = on_node ? up_data.node_coeff : up_data.dev_coeff;
	assign coeff_s1  = on_node ? acc_s1.node_coeff : acc_s1.dev_coeff;
	assign idx_s1    = on_node ? acc_s1.node_sum : acc_s1.dev_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= up_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// First stage: coefficient times coordinate, and degree times stride.
	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			acc_s1   <= up_data;
			part_s1  <= tdcm_pkg::sat_mul(sel_coeff,
				tdcm_pkg::INDEX_W'(up_data.coord[0]));
			scale_s1 <= tdcm_pkg::INDEX_W'(degree) * tdcm_pkg::INDEX_W'(stride);
		end
	end

	assign term      = tdcm_pkg::sat_mul(part_s1, tdcm_pkg::INDEX_W'(stride));
	assign new_idx   = tdcm_pkg::sat_add(idx_s1, term);
	assign new_coeff = tdcm_pkg::sat_mul(coeff_s1, scale_s1);

	always_comb begin
		next_acc       = acc_s1;
		next_acc.coord = {{tdcm_pkg::COORD_W{1'b0}},
			acc_s1.coord[tdcm_pkg::DIM_LIMIT-1:1]};
		if (active) begin
			if (on_node) begin
				next_acc.node_sum   = new_idx;
				next_acc.node_coeff = new_coeff;
			end else begin
				next_acc.dev_sum   = new_idx;
				next_acc.dev_coeff = new_coeff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			acc_s2 <= next_acc;
		end
	end

endmodule

FILE: hdl/tdcm_out.sv
// ----------------------------------------------------------------------------
// Task-to-device coordinate map: result stage
// Saturates both indices, checks them against the machine bounds and holds
// the result until the downstream transfer.
// ----------------------------------------------------------------------------
module tdcm_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tdcm_pkg::FIELD_W-1:0]  node_count,
	input  logic [tdcm_pkg::FIELD_W-1:0]  devices_per_node,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  tdcm_pkg::acc_t                up_data,
	tdcm_result_if.source                 result
);

	logic                               valid_q;
	logic [tdcm_pkg::INDEX_W-1:0]       node_q;
	logic [tdcm_pkg::INDEX_W-1:0]       dev_q;
	logic                               inside_q;
	logic                               node_ok;
	logic                               dev_ok;

	assign up_ready = !valid_q || result.ready;

	assign node_ok = !up_data.node_sum[tdcm_pkg::INDEX_W] &&
		(up_data.node_sum < tdcm_pkg::SAT_W'(node_count));
	assign dev_ok  = !up_data.dev_sum[tdcm_pkg::INDEX_W] &&
		(up_data.dev_sum < tdcm_pkg::SAT_W'(devices_per_node));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			node_q   <= up_data.node_sum[tdcm_pkg::INDEX_W] ?
				'1 : up_data.node_sum[tdcm_pkg::INDEX_W-1:0];
			dev_q    <= up_data.dev_sum[tdcm_pkg::INDEX_W] ?
				'1 : up_data.dev_sum[tdcm_pkg::INDEX_W-1:0];
			inside_q <= node_ok && dev_ok;
		end
	end

	assign result.valid            = valid_q;
	assign result.node_index       = node_q;
	assign result.device_index     = dev_q;
	assign result.coordinate_valid = inside_q;

endmodule

FILE: bench/tb_task_to_device_coordinate_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the task-to-device coordinate map
// A directed table of settings and coordinates comes first: saturation,
// zero counts, no active dimensions, and an all-node projection. Random phases
// follow, each with its own register settings and, but for the closing two, random
// idling on both channels. Every result is compared with a table value or with an in-bench model of the mapping.
// ----------------------------------------------------------------------------
module tb_task_to_device_coordinate_map;

	localparam int ITEMS_PER_PHASE = 96;
	localparam int RANDOM_PHASES   = 16;
	localparam int SETTLE_CYCLES   = 2*tdcm_pkg::DIM_LIMIT + 4;
	localparam int LONG_HOLD       = 300;
	localparam int RUN_LIMIT_NS    = 2_000_000;

	localparam logic [63:0] INDEX_CAP = 64'h1_0000_0000;

	typedef logic [tdcm_pkg::DIM_LIMIT-1:0][tdcm_pkg::COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [tdcm_pkg::INDEX_W-1:0] node_index;
		logic [tdcm_pkg::INDEX_W-1:0] device_index;
		logic                         coordinate_valid;
	} map_result_t;

	typedef struct packed {
		logic [2:0]                   active;
		logic [63:0]                  degrees;
		logic [63:0]                  strides;
		logic [3:0]                   mask;
		logic [tdcm_pkg::FIELD_W-1:0] start_node;
		logic [tdcm_pkg::FIELD_W-1:0] start_device;
		logic [tdcm_pkg::FIELD_W-1:0] node_count;
		logic [tdcm_pkg::FIELD_W-1:0] device_count;
	} map_settings_t;

	typedef enum logic [2:0] {
		SET_RESET,
		SET_SATURATE,
		SET_NO_DIMS,
		SET_ZERO_COUNTS,
		SET_NODE_AXIS
	} preset_t;

	typedef struct packed {
		preset_t     preset;
		logic        typed;
		coord_t      crd;
		map_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        write_enable;
	logic [2:0]  write_index;
	logic [63:0] write_data;

	tdcm_coord_if  task_coord ();
	tdcm_result_if device_coord ();

	map_settings_t map_cfg;
	map_result_t   expected_maps[$];
	int            mismatch_count = 0;
	int            hold_requests = 0;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;

	task_to_device_coordinate_map uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.task_coord   (task_coord),
		.device_coord (device_coord)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Values are held as min(true value, 2^32); 2^32 stands for any overflow.
	function automatic logic [63:0] capped_product(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		if (a == 64'd0 || b == 64'd0)
			return 64'd0;
		if (a >= INDEX_CAP || b >= INDEX_CAP || p > INDEX_CAP)
			return INDEX_CAP;
		return p;
	endfunction

	function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a >= INDEX_CAP || b >= INDEX_CAP || s > INDEX_CAP)
			return INDEX_CAP;
		return s;
	endfunction

	function automatic logic [63:0] axis_offset(input coord_t c,
			input logic [tdcm_pkg::FIELD_W-1:0] origin, input logic node_axis);
		logic [63:0] coeff;
		logic [63:0] acc;
		logic [63:0] deg;
		logic [63:0] str;
		int          dims;
		dims  = (map_cfg.active > tdcm_pkg::DIM_LIMIT) ? tdcm_pkg::DIM_LIMIT
			: int'(map_cfg.active);
		coeff = 64'd1;
		acc   = 64'(origin);
		for (int j = 0; j < dims; j++) begin
			deg = 64'(map_cfg.degrees[tdcm_pkg::FIELD_W*j +: tdcm_pkg::FIELD_W]);
			str = 64'(map_cfg.strides[tdcm_pkg::FIELD_W*j +: tdcm_pkg::FIELD_W]);
			if (map_cfg.mask[j] == node_axis) begin
				acc   = capped_sum(acc, capped_product(capped_product(coeff, 64'(c[j])), str));
				coeff = capped_product(coeff, deg * str);
			end
		end
		return acc;
	endfunction

	function automatic map_result_t predict_map(input coord_t c);
		logic [63:0] node;
		logic [63:0] dev;
		map_result_t r;
		node = axis_offset(c, map_cfg.start_node, 1'b1);
		dev  = axis_offset(c, map_cfg.start_device, 1'b0);
		r.node_index       = (node >= INDEX_CAP) ? '1 : node[tdcm_pkg::INDEX_W-1:0];
		r.device_index     = (dev >= INDEX_CAP) ? '1 : dev[tdcm_pkg::INDEX_W-1:0];
		r.coordinate_valid = node < INDEX_CAP && dev < INDEX_CAP &&
			node < 64'(map_cfg.node_count) && dev < 64'(map_cfg.device_count);
		return r;
	endfunction

	function automatic int reg_width(input logic [2:0] idx);
		case (idx)
			tdcm_pkg::REG_ACTIVE_DIMS: return 3;
			tdcm_pkg::REG_DEGREES, tdcm_pkg::REG_STRIDES: return 64;
			tdcm_pkg::REG_PROJECTION: return 4;
			default: return tdcm_pkg::FIELD_W;
		endcase
	endfunction

	function automatic stim_row_t stim_row(input preset_t p, input logic [15:0] c0,
			input logic [15:0] c1, input logic [15:0] c2, input logic [15:0] c3, input logic typed,
			input logic [31:0] node, input logic [31:0] dev, input logic ok);
		stim_row_t r;
		r.preset                = p;
		r.typed                 = typed;
		r.crd                   = {c3, c2, c1, c0};
		r.want.node_index       = node;
		r.want.device_index     = dev;
		r.want.coordinate_valid = ok;
		return r;
	endfunction

	function automatic map_settings_t preset_settings(input preset_t p);
		map_settings_t s;
		s.active       = 3'd1;
		s.degrees      = 64'd1;
		s.strides      = 64'd1;
		s.mask         = 4'd0;
		s.start_node   = '0;
		s.start_device = '0;
		s.node_count   = 16'd1;
		s.device_count = 16'd1;
		case (p)
			SET_SATURATE: begin
				s.active       = 3'd4;
				s.degrees      = '1;
				s.strides      = '1;
				s.node_count   = '1;
				s.device_count = '1;
			end
			SET_NO_DIMS: begin
				s.active       = 3'd0;
				s.degrees      = 64'h0007_0003_0002_0005;
				s.strides      = 64'h0002_0001_0003_0001;
				s.mask         = 4'hF;
				s.start_node   = '1;
				s.start_device = '1;
				s.node_count   = '1;
				s.device_count = '1;
			end
			SET_ZERO_COUNTS: begin
				// More dimensions than exist, a zero degree and a zero stride.
				s.active       = 3'd7;
				s.degrees      = 64'h0003_0000_0005_0002;
				s.strides      = 64'h0001_0002_0000_0003;
				s.mask         = 4'b0101;
				s.start_node   = 16'd5;
				s.start_device = 16'd7;
				s.node_count   = '0;
				s.device_count = '0;
			end
			SET_NODE_AXIS: begin
				s.active     = 3'd4;
				s.degrees    = 64'h0004_0004_0004_0004;
				s.mask       = 4'hF;
				s.node_count = 16'd256;
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic logic [15:0] pick_field(input int small_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 16'($urandom_range(1, small_max));
		if (r < 85)
			return '0;
		if (r < 92)
			return '1;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return '1;
		if (r < 70)
			return 16'($urandom_range(1, 1024));
		if (r < 80)
			return '0;
		return 16'($urandom);
	endfunction

	// Unused high bits of the write data carry junk at random; the block
	// must ignore them.
	task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
		logic [63:0] junk;
		int          width;
		junk  = {$urandom, $urandom};
		width = reg_width(idx);
		if (width < 64 && $urandom_range(0, 1) == 1)
			value = value | (junk << width);
		write_enable <= 1'b1;
		write_index  <= idx;
		write_data   <= value;
		@(posedge clk);
		case (idx)
			tdcm_pkg::REG_ACTIVE_DIMS:   map_cfg.active       = value[2:0];
			tdcm_pkg::REG_DEGREES:       map_cfg.degrees      = value;
			tdcm_pkg::REG_STRIDES:       map_cfg.strides      = value;
			tdcm_pkg::REG_PROJECTION:    map_cfg.mask         = value[3:0];
			tdcm_pkg::REG_START_NODE:    map_cfg.start_node   = value[tdcm_pkg::FIELD_W-1:0];
			tdcm_pkg::REG_START_DEVICE:  map_cfg.start_device = value[tdcm_pkg::FIELD_W-1:0];
			tdcm_pkg::REG_NODE_COUNT:    map_cfg.node_count   = value[tdcm_pkg::FIELD_W-1:0];
			tdcm_pkg::REG_DEVS_PER_NODE: map_cfg.device_count = value[tdcm_pkg::FIELD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input map_settings_t s);
		write_register(tdcm_pkg::REG_ACTIVE_DIMS, 64'(s.active));
		write_register(tdcm_pkg::REG_DEGREES, s.degrees);
		write_register(tdcm_pkg::REG_STRIDES, s.strides);
		write_register(tdcm_pkg::REG_PROJECTION, 64'(s.mask));
		write_register(tdcm_pkg::REG_START_NODE, 64'(s.start_node));
		write_register(tdcm_pkg::REG_START_DEVICE, 64'(s.start_device));
		write_register(tdcm_pkg::REG_NODE_COUNT, 64'(s.node_count));
		write_register(tdcm_pkg::REG_DEVS_PER_NODE, 64'(s.device_count));
		write_enable <= 1'b0;
	endtask

	task automatic drain_pipeline();
		task_coord.valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Called at a rising edge; returns at the edge where the transfer happened.
	task automatic offer_coord(input coord_t c, input map_result_t typed_want, input logic typed);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			task_coord.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		task_coord.valid       <= 1'b1;
		task_coord.coord_zero  <= c[0];
		task_coord.coord_one   <= c[1];
		task_coord.coord_two   <= c[2];
		task_coord.coord_three <= c[3];
		@(posedge clk);
		while (!task_coord.ready)
			@(posedge clk);
		expected_maps.push_back(typed ? typed_want : predict_map(c));
	endtask

	always @(posedge clk) begin : result_check
		map_result_t want;
		if (arst_n && device_coord.valid && device_coord.ready) begin
			if (expected_maps.size() == 0) begin
				$error("result transfer with no expected result: node_index %0h device_index %0h",
					device_coord.node_index, device_coord.device_index);
				mismatch_count++;
			end else begin
				want = expected_maps.pop_front();
				if (device_coord.node_index !== want.node_index) begin
					$error("node_index: expected %0h, got %0h", want.node_index,
						device_coord.node_index);
					mismatch_count++;
				end
				if (device_coord.device_index !== want.device_index) begin
					$error("device_index: expected %0h, got %0h", want.device_index,
						device_coord.device_index);
					mismatch_count++;
				end
				if (device_coord.coordinate_valid !== want.coordinate_valid) begin
					$error("coordinate_valid: expected %0b, got %0b", want.coordinate_valid,
						device_coord.coordinate_valid);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		device_coord.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				device_coord.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				device_coord.ready <= 1'b1;
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				device_coord.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				device_coord.ready <= 1'b1;
			end else begin
				device_coord.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		stim_row_t     directed_rows[$];
		map_settings_t s;
		coord_t        c;
		preset_t       loaded;
		logic [15:0]   deg;
		int            r;

		arst_n                 = 1'b0;
		write_enable           = 1'b0;
		write_index            = tdcm_pkg::REG_ACTIVE_DIMS;
		write_data             = '0;
		task_coord.valid       = 1'b0;
		task_coord.coord_zero  = '0;
		task_coord.coord_one   = '0;
		task_coord.coord_two   = '0;
		task_coord.coord_three = '0;
		map_cfg                = preset_settings(SET_RESET);
		loaded                 = SET_RESET;

		// Reset values: one device dimension, both counts one.
		directed_rows.push_back(stim_row(SET_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b1, 32'h0, 32'h0, 1'b1));
		directed_rows.push_back(stim_row(SET_RESET, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 32'h0, 32'h1, 1'b0));
		directed_rows.push_back(stim_row(SET_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 32'h0, 32'hFFFF, 1'b0));
		// All degrees and strides at their maximum: the device index can overflow.
		directed_rows.push_back(stim_row(SET_SATURATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b1, 32'h0, 32'h0, 1'b1));
		directed_rows.push_back(stim_row(SET_SATURATE, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
			1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0));
		directed_rows.push_back(stim_row(SET_SATURATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0));
		directed_rows.push_back(stim_row(SET_SATURATE, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
			1'b1, 32'h0, 32'hFFFF, 1'b0));
		directed_rows.push_back(stim_row(SET_SATURATE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			1'b0, '0, '0, 1'b0));
		directed_rows.push_back(stim_row(SET_SATURATE, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
			1'b0, '0, '0, 1'b0));
		// No active dimensions: both indices sit at their start offsets.
		directed_rows.push_back(stim_row(SET_NO_DIMS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 32'hFFFF, 32'hFFFF, 1'b0));
		directed_rows.push_back(stim_row(SET_NO_DIMS, 16'h1234, 16'h0000, 16'h8000, 16'h0001,
			1'b1, 32'hFFFF, 32'hFFFF, 1'b0));
		directed_rows.push_back(stim_row(SET_ZERO_COUNTS, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b1, 32'h5, 32'h7, 1'b0));
		directed_rows.push_back(stim_row(SET_ZERO_COUNTS, 16'h0001, 16'h0004, 16'h0001, 16'h0002,
			1'b0, '0, '0, 1'b0));
		directed_rows.push_back(stim_row(SET_ZERO_COUNTS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b0, '0, '0, 1'b0));
		directed_rows.push_back(stim_row(SET_NODE_AXIS, 16'h0003, 16'h0003, 16'h0003, 16'h0003,
			1'b0, '0, '0, 1'b0));
		directed_rows.push_back(stim_row(SET_NODE_AXIS, 16'h0000, 16'h0000, 16'h0000, 16'h0004,
			1'b0, '0, '0, 1'b0));
		directed_rows.push_back(stim_row(SET_NODE_AXIS, 16'h0002, 16'h0001, 16'h0000, 16'h0001,
			1'b0, '0, '0, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].preset != loaded) begin
				drain_pipeline();
				loaded = directed_rows[i].preset;
				load_settings(preset_settings(loaded));
			end
			offer_coord(directed_rows[i].crd, directed_rows[i].want, directed_rows[i].typed);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_pipeline();
			s.active = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(1, 4))
				: 3'($urandom_range(0, 7));
			for (int j = 0; j < tdcm_pkg::DIM_LIMIT; j++) begin
				s.degrees[tdcm_pkg::FIELD_W*j +: tdcm_pkg::FIELD_W] = pick_field(8);
				s.strides[tdcm_pkg::FIELD_W*j +: tdcm_pkg::FIELD_W] = pick_field(3);
			end
			s.mask         = 4'($urandom);
			s.start_node   = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 7))
				: 16'($urandom);
			s.start_device = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 7))
				: 16'($urandom);
			s.node_count   = pick_count();
			s.device_count = pick_count();
			load_settings(s);

			// The closing phases run with both channels at full rate.
			if (phase >= RANDOM_PHASES - 2) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end else begin
				r = $urandom_range(0, 2);
				tx_idle_pct = (r == 0) ? 0 : (r == 1) ? 10 : 30;
				r = $urandom_range(0, 2);
				rx_idle_pct <= (r == 0) ? 0 : (r == 1) ? 10 : 30;
			end
			// The receiver stops for a long stretch so the block backs up.
			if (phase == 2)
				hold_requests <= hold_requests + 1;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 3 && n == ITEMS_PER_PHASE/2)
					drain_pipeline();
				for (int j = 0; j < tdcm_pkg::DIM_LIMIT; j++) begin
					deg = map_cfg.degrees[tdcm_pkg::FIELD_W*j +: tdcm_pkg::FIELD_W];
					r   = $urandom_range(0, 99);
					if (r < 70)
						c[j] = (deg == 0) ? '0 : 16'($urandom_range(0, deg - 1));
					else if (r < 85)
						c[j] = 16'($urandom);
					else if (r < 92)
						c[j] = '0;
					else if (r < 97)
						c[j] = '1;
					else
						c[j] = deg;
				end
				offer_coord(c, '0, 1'b0);
			end
		end

		drain_pipeline();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
